### design/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// shared widths, stage indexes and pipeline types of the face normal block
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_W   = 16;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int MAG_W     = PROD_W;
    localparam int HALF_W    = MAG_W / 2;
    localparam int SUM_W     = 2 * MAG_W + 4;
    localparam int ROOT_W    = 36;
    localparam int FRAC_W    = 14;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int NUM_W     = MAG_W + FRAC_W;
    localparam int DIVS_W    = ROOT_W + FRAC_W;
    localparam int OUT_W     = 16;
    localparam int MINLEN_W  = 16;

    localparam int ST_EDGE   = 0;
    localparam int ST_PROD   = 1;
    localparam int ST_CROSS  = 2;
    localparam int ST_PART   = 3;
    localparam int ST_SQ     = 4;
    localparam int ST_SUM    = 5;
    localparam int SQ_FIRST  = 6;
    localparam int SQ_LAST   = SQ_FIRST + ROOT_W - 1;
    localparam int ST_DSET   = SQ_LAST + 1;
    localparam int DIV_FIRST = ST_DSET + 1;
    localparam int DIV_LAST  = DIV_FIRST + QUO_W - 1;
    localparam int ST_OUT    = DIV_LAST + 1;
    localparam int N_STAGES  = ST_OUT + 1;

    localparam logic [2:0] ADDR_MIN_LENGTH = 3'd0;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            sgn;
    } t_carry;

    typedef struct packed {
        logic [2:0][OUT_W-1:0] normal;
        logic                  degen;
    } t_result;

endpackage

### design/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// unit face normal of one triangle, q8.8 corners in, q1.14 normal out
// throughput: one triangle per cycle while the output is not stalled, set by the
// bit-per-stage square root and the bit-per-stage dividers, all fully pipelined
// reset: synchronous active low, clears valid bits and sets min_length to 66
// ----------------------------------------------------------------------------
module triangle_face_normal (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // apb configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  logic [143:0] i_s_tdata,
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // normal_x, normal_y, normal_z
    output logic [47:0]  o_m_tdata,
    // degenerate
    output logic [0:0]   o_m_tuser
);

    localparam int N = tfn_pkg::N_STAGES;

    logic [tfn_pkg::MINLEN_W-1:0] r_min_length;
    logic [N-1:0]                 r_v;
    logic                         en;
    logic                         r_sk_v;
    tfn_pkg::t_result             r_skid;
    tfn_pkg::t_result             r_out;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= tfn_pkg::MINLEN_W'(66);
        end else if (psel && penable && pwrite && (paddr[2] == tfn_pkg::ADDR_MIN_LENGTH[2])) begin
            r_min_length <= pwdata[tfn_pkg::MINLEN_W-1:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == tfn_pkg::ADDR_MIN_LENGTH[2]) begin
            prdata = {{(32-tfn_pkg::MINLEN_W){1'b0}}, r_min_length};
        end
    end

    // pipeline moves whenever the skid stage is empty
    assign en         = !r_sk_v;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[N-2:0], i_s_tvalid};
        end
    end

    // edges
    logic signed [tfn_pkg::EDGE_W-1:0] r_e1 [3];
    logic signed [tfn_pkg::EDGE_W-1:0] r_e2 [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_e1[j] <= tfn_pkg::EDGE_W'($signed(i_s_tdata[16*j +: 16]))
                         - tfn_pkg::EDGE_W'($signed(i_s_tdata[16*(j+3) +: 16]));
                r_e2[j] <= tfn_pkg::EDGE_W'($signed(i_s_tdata[16*j +: 16]))
                         - tfn_pkg::EDGE_W'($signed(i_s_tdata[16*(j+6) +: 16]));
            end
        end
    end

    // cross product terms
    logic signed [tfn_pkg::PROD_W-1:0] r_pa [3];
    logic signed [tfn_pkg::PROD_W-1:0] r_pb [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa[0] <= r_e2[1] * r_e1[2];
            r_pb[0] <= r_e2[2] * r_e1[1];
            r_pa[1] <= r_e2[2] * r_e1[0];
            r_pb[1] <= r_e2[0] * r_e1[2];
            r_pa[2] <= r_e2[0] * r_e1[1];
            r_pb[2] <= r_e2[1] * r_e1[0];
        end
    end

    // cross product, magnitude and sign
    tfn_pkg::t_carry r_cy [tfn_pkg::ST_CROSS:tfn_pkg::ST_DSET];
    logic signed [tfn_pkg::PROD_W:0] n_cross [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_cross[j] = (tfn_pkg::PROD_W+1)'(r_pa[j]) - (tfn_pkg::PROD_W+1)'(r_pb[j]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_cy[tfn_pkg::ST_CROSS].sgn[j] <= n_cross[j][tfn_pkg::PROD_W];
                r_cy[tfn_pkg::ST_CROSS].mag[j] <= n_cross[j][tfn_pkg::PROD_W]
                    ? tfn_pkg::MAG_W'(-n_cross[j]) : tfn_pkg::MAG_W'(n_cross[j]);
            end
        end
    end

    generate
        for (genvar k = tfn_pkg::ST_CROSS + 1; k <= tfn_pkg::ST_DSET; k++) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_cy[k] <= r_cy[k-1];
                end
            end
        end
    endgenerate

    // partial squares
    logic [2*tfn_pkg::HALF_W-1:0] r_hh [3];
    logic [2*tfn_pkg::HALF_W-1:0] r_hl [3];
    logic [2*tfn_pkg::HALF_W-1:0] r_ll [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_hh[j] <= r_cy[tfn_pkg::ST_CROSS].mag[j][tfn_pkg::MAG_W-1 -: tfn_pkg::HALF_W]
                         * r_cy[tfn_pkg::ST_CROSS].mag[j][tfn_pkg::MAG_W-1 -: tfn_pkg::HALF_W];
                r_hl[j] <= r_cy[tfn_pkg::ST_CROSS].mag[j][tfn_pkg::MAG_W-1 -: tfn_pkg::HALF_W]
                         * r_cy[tfn_pkg::ST_CROSS].mag[j][tfn_pkg::HALF_W-1:0];
                r_ll[j] <= r_cy[tfn_pkg::ST_CROSS].mag[j][tfn_pkg::HALF_W-1:0]
                         * r_cy[tfn_pkg::ST_CROSS].mag[j][tfn_pkg::HALF_W-1:0];
            end
        end
    end

    // full squares
    logic [tfn_pkg::SUM_W-1:0] r_sq [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_sq[j] <= (tfn_pkg::SUM_W'(r_hh[j]) << (2*tfn_pkg::HALF_W))
                         + (tfn_pkg::SUM_W'(r_hl[j]) << (tfn_pkg::HALF_W+1))
                         + tfn_pkg::SUM_W'(r_ll[j]);
            end
        end
    end

    // square root, one root bit per stage
    logic [tfn_pkg::SUM_W-1:0]  r_rem  [tfn_pkg::ST_SUM:tfn_pkg::SQ_LAST];
    logic [tfn_pkg::ROOT_W-1:0] r_root [tfn_pkg::ST_SUM:tfn_pkg::SQ_LAST];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[tfn_pkg::ST_SUM]  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_root[tfn_pkg::ST_SUM] <= '0;
        end
    end

    generate
        for (genvar k = tfn_pkg::SQ_FIRST; k <= tfn_pkg::SQ_LAST; k++) begin : g_sqrt
            localparam int B = tfn_pkg::SQ_LAST - k;
            logic [tfn_pkg::SUM_W-1:0] trial;
            assign trial = (tfn_pkg::SUM_W'(r_root[k-1]) << (B+1))
                         | (tfn_pkg::SUM_W'(1) << (2*B));
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (trial <= r_rem[k-1]) begin
                        r_rem[k]  <= r_rem[k-1] - trial;
                        r_root[k] <= r_root[k-1] | (tfn_pkg::ROOT_W'(1) << B);
                    end else begin
                        r_rem[k]  <= r_rem[k-1];
                        r_root[k] <= r_root[k-1];
                    end
                end
            end
        end
    endgenerate

    // degenerate check and divider setup
    logic [tfn_pkg::ROOT_W-1:0] r_len   [tfn_pkg::ST_DSET:tfn_pkg::DIV_LAST];
    logic                       r_degen [tfn_pkg::ST_DSET:tfn_pkg::DIV_LAST];
    logic [2:0]                 r_sgn   [tfn_pkg::ST_DSET:tfn_pkg::DIV_LAST];
    logic [tfn_pkg::NUM_W-1:0]  r_drem  [tfn_pkg::ST_DSET:tfn_pkg::DIV_LAST][3];
    logic [tfn_pkg::QUO_W-1:0]  r_quo   [tfn_pkg::ST_DSET:tfn_pkg::DIV_LAST][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_len[tfn_pkg::ST_DSET]   <= r_root[tfn_pkg::SQ_LAST];
            r_degen[tfn_pkg::ST_DSET] <= (r_root[tfn_pkg::SQ_LAST] == '0)
                || (r_root[tfn_pkg::SQ_LAST] < tfn_pkg::ROOT_W'(r_min_length));
            r_sgn[tfn_pkg::ST_DSET]   <= r_cy[tfn_pkg::SQ_LAST].sgn;
            for (int j = 0; j < 3; j++) begin
                r_drem[tfn_pkg::ST_DSET][j] <= {r_cy[tfn_pkg::SQ_LAST].mag[j],
                                                {tfn_pkg::FRAC_W{1'b0}}};
                r_quo[tfn_pkg::ST_DSET][j]  <= '0;
            end
        end
    end

    // restoring dividers, one quotient bit per stage
    generate
        for (genvar k = tfn_pkg::DIV_FIRST; k <= tfn_pkg::DIV_LAST; k++) begin : g_div
            localparam int Q = tfn_pkg::DIV_LAST - k;
            logic [tfn_pkg::DIVS_W-1:0] dsh;
            assign dsh = tfn_pkg::DIVS_W'(r_len[k-1]) << Q;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_len[k]   <= r_len[k-1];
                    r_degen[k] <= r_degen[k-1];
                    r_sgn[k]   <= r_sgn[k-1];
                    for (int j = 0; j < 3; j++) begin
                        if (tfn_pkg::DIVS_W'(r_drem[k-1][j]) >= dsh) begin
                            r_drem[k][j] <= tfn_pkg::NUM_W'(tfn_pkg::DIVS_W'(r_drem[k-1][j]) - dsh);
                            r_quo[k][j]  <= r_quo[k-1][j] | (tfn_pkg::QUO_W'(1) << Q);
                        end else begin
                            r_drem[k][j] <= r_drem[k-1][j];
                            r_quo[k][j]  <= r_quo[k-1][j];
                        end
                    end
                end
            end
        end
    endgenerate

    // sign, zero on degenerate, output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.degen <= r_degen[tfn_pkg::DIV_LAST];
            for (int j = 0; j < 3; j++) begin
                if (r_degen[tfn_pkg::DIV_LAST]) begin
                    r_out.normal[j] <= '0;
                end else if (r_sgn[tfn_pkg::DIV_LAST][j]) begin
                    r_out.normal[j] <= -tfn_pkg::OUT_W'(r_quo[tfn_pkg::DIV_LAST][j]);
                end else begin
                    r_out.normal[j] <= tfn_pkg::OUT_W'(r_quo[tfn_pkg::DIV_LAST][j]);
                end
            end
        end
    end

    // skid stage holds a word the sink did not take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (i_m_tready) begin
                r_sk_v <= 1'b0;
            end
        end else if (r_v[N-1] && !i_m_tready) begin
            r_sk_v <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!r_sk_v) begin
            r_skid <= r_out;
        end
    end

    tfn_pkg::t_result res;
    assign res        = r_sk_v ? r_skid : r_out;
    assign o_m_tvalid = r_sk_v || r_v[N-1];
    assign o_m_tdata  = {res.normal[2], res.normal[1], res.normal[0]};
    assign o_m_tuser  = res.degen;

endmodule
